>>> hw/rtl/rci_pkg.sv
// shared widths, register map and pipeline record types for the ray / circle intersector
package rci_pkg;

  localparam int CW   = 32;            // coordinate width
  localparam int FW   = 16;            // fraction bits of coordinates
  localparam int NF   = 14;            // fraction bits of the normal
  localparam int NOW  = 16;            // normal output width
  localparam int TW   = CW - 1;        // unsigned distance width

  localparam int OCW  = CW + 1;        // origin minus center
  localparam int AW   = 2 * CW;        // |d|^2
  localparam int HW   = 2 * CW + 2;    // half-b term, signed
  localparam int CCW  = 2 * CW + 3;    // c term, signed
  localparam int HMW  = 2 * CW + 1;    // |h|
  localparam int CMW  = 2 * CW + 2;    // |c|
  localparam int SPL  = CW + 1;        // split point of the wide products
  localparam int DW   = 4 * CW + 2;    // discriminant
  localparam int SQW  = DW / 2;        // its root
  localparam int RM1  = SQW + 2;       // root remainder
  localparam int NSW  = 2 * CW + 4;    // root numerators, signed
  localparam int NMW  = NSW - 1;

  localparam int PW   = CW + TW;       // dir * t
  localparam int PXW  = PW - FW + 1;   // unsaturated hit point
  localparam int VW   = PXW + 1;       // hit point minus center
  localparam int VMW  = VW - 1;
  localparam int VSP  = VMW / 2;
  localparam int SSW  = 2 * VMW + 1;   // |v|^2
  localparam int SS2  = 2 * ((SSW + 1) / 2);
  localparam int LW   = SS2 / 2;       // |v|
  localparam int RM2  = LW + 2;
  localparam int NQW  = NF + 1;        // normal quotient

  localparam int NORM_ONE = 1 << NF;

  // registers on the path from an accepted item to its done strobe
  localparam int LAT  = 6 + 1 + SQW + 2 + 1 + TW + 6 + 1 + LW + 1 + NQW + 1;

  localparam int PAW  = 4;
  localparam int RIW  = PAW - 2;
  localparam logic [RIW-1:0] REG_CX = RIW'(0);
  localparam logic [RIW-1:0] REG_CY = RIW'(1);
  localparam logic [RIW-1:0] REG_R  = RIW'(2);
  localparam logic [TW-1:0]  R_RESET = TW'(1) << FW;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [TW-1:0]        md;
    logic                 miss;
  } ray_t;

  typedef struct packed {
    logic signed [HW-1:0] h;
    logic [AW-1:0]        a;
    ray_t                 r;
  } fr_t;

  typedef struct packed {
    logic [RM1-1:0] rem;
    logic [SQW-1:0] root;
    logic [DW-1:0]  rad;
    fr_t            sb;
  } sq1_t;

  typedef struct packed {
    logic [AW-1:0] rem;
    logic [TW-1:0] q;
    logic [TW-1:0] nlo;
    logic [AW-1:0] a;
    ray_t          r;
  } dv_t;

  typedef struct packed {
    logic                 hit;
    logic [TW-1:0]        t;
    logic signed [CW-1:0] hitx;
    logic signed [CW-1:0] hity;
    logic [VMW-1:0]       vxm;
    logic [VMW-1:0]       vym;
    logic                 vxn;
    logic                 vyn;
  } hp_t;

  typedef struct packed {
    logic [RM2-1:0] rem;
    logic [LW-1:0]  root;
    logic [SS2-1:0] rad;
    hp_t            sb;
  } sq2_t;

  typedef struct packed {
    logic [LW-1:0]  len;
    logic [LW-1:0]  remx;
    logic [NQW-1:0] qx;
    logic [NQW-1:0] nlx;
    logic [LW-1:0]  remy;
    logic [NQW-1:0] qy;
    logic [NQW-1:0] nly;
    hp_t            sb;
  } dn_t;

endpackage

>>> hw/rtl/ray_circle_intersect.sv
// ray / circle intersector: fixed-point quadratic solve, fully pipelined
// Takes one ray per clock (busy stays low) and returns one result per ray, in order, on a
// one-cycle done strobe. The pipeline depth is dominated by the bit-serial stages: the
// discriminant square root (65 stages), the distance divider (31), the normal-length square
// root (49) and the normal dividers (15), each retiring one result bit per stage. A miss
// returns hit low and all other fields zero. The user must write center and radius over
// the APB port only while no ray is in flight; the block itself does not enforce it.
module ray_circle_intersect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rci_pkg::PAW-1:0]          paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic signed [rci_pkg::CW-1:0]    origin_x,
  input  logic signed [rci_pkg::CW-1:0]    origin_y,
  input  logic signed [rci_pkg::CW-1:0]    dir_x,
  input  logic signed [rci_pkg::CW-1:0]    dir_y,
  input  logic [rci_pkg::TW-1:0]           max_dist,
  output logic                             done,
  output logic                             hit,
  output logic [rci_pkg::TW-1:0]           hit_t,
  output logic signed [rci_pkg::CW-1:0]    hit_x,
  output logic signed [rci_pkg::CW-1:0]    hit_y,
  output logic signed [rci_pkg::NOW-1:0]   normal_x,
  output logic signed [rci_pkg::NOW-1:0]   normal_y
);
  import rci_pkg::*;

  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic [TW-1:0]        circle_radius;
  logic                 cfg_wr;
  logic [LAT-1:0]       vld;

  // step functions of the bit-serial units
  function automatic sq1_t sq1_step(input sq1_t s);
    logic [RM1-1:0] sh;
    logic [RM1-1:0] tr;
    sq1_t o;
    o = s;
    sh = {s.rem[RM1-3:0], s.rad[DW-1 -: 2]};
    tr = {s.root, 2'b01};
    o.rad = s.rad << 2;
    if (sh >= tr) begin
      o.rem  = sh - tr;
      o.root = {s.root[SQW-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[SQW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq2_t sq2_step(input sq2_t s);
    logic [RM2-1:0] sh;
    logic [RM2-1:0] tr;
    sq2_t o;
    o = s;
    sh = {s.rem[RM2-3:0], s.rad[SS2-1 -: 2]};
    tr = {s.root, 2'b01};
    o.rad = s.rad << 2;
    if (sh >= tr) begin
      o.rem  = sh - tr;
      o.root = {s.root[LW-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[LW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t s);
    logic [AW:0] sh;
    dv_t o;
    o = s;
    sh = {s.rem, s.nlo[TW-1]};
    o.nlo = s.nlo << 1;
    if (sh >= {1'b0, s.a}) begin
      o.rem = AW'(sh - {1'b0, s.a});
      o.q   = {s.q[TW-2:0], 1'b1};
    end else begin
      o.rem = sh[AW-1:0];
      o.q   = {s.q[TW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dn_t dn_step(input dn_t s);
    logic [LW:0] shx;
    logic [LW:0] shy;
    dn_t o;
    o = s;
    shx = {s.remx, s.nlx[NQW-1]};
    shy = {s.remy, s.nly[NQW-1]};
    o.nlx = s.nlx << 1;
    o.nly = s.nly << 1;
    if (shx >= {1'b0, s.len}) begin
      o.remx = LW'(shx - {1'b0, s.len});
      o.qx   = {s.qx[NQW-2:0], 1'b1};
    end else begin
      o.remx = shx[LW-1:0];
      o.qx   = {s.qx[NQW-2:0], 1'b0};
    end
    if (shy >= {1'b0, s.len}) begin
      o.remy = LW'(shy - {1'b0, s.len});
      o.qy   = {s.qy[NQW-2:0], 1'b1};
    end else begin
      o.remy = shy[LW-1:0];
      o.qy   = {s.qy[NQW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ray_t with_miss(input ray_t r, input logic m);
    ray_t o;
    o = r;
    o.miss = m;
    return o;
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [PXW-1:0] p);
    logic signed [CW-1:0] r;
    if ((&p[PXW-1:CW-1]) || !(|p[PXW-1:CW-1])) begin
      r = p[CW-1:0];
    end else if (p[PXW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      circle_radius <= R_RESET;
    end else if (cfg_wr) begin
      case (paddr[PAW-1:2])
        REG_CX:  center_x      <= pwdata[CW-1:0];
        REG_CY:  center_y      <= pwdata[CW-1:0];
        REG_R:   circle_radius <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PAW-1:2])
      REG_CX:  prdata = center_x;
      REG_CY:  prdata = center_y;
      REG_R:   prdata = {1'b0, circle_radius};
      default: prdata = '0;
    endcase
  end

  // valid line, one bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end
  assign done = vld[LAT-1];

  // front end: offsets, offset and direction products, quadratic terms
  logic signed [OCW-1:0]    e0_ocx, e0_ocy;
  logic signed [CW-1:0]     e0_ox, e0_oy, e0_dx, e0_dy;
  logic [TW-1:0]            e0_md, e0_r;
  logic signed [2*CW-1:0]   e1_dxx, e1_dyy;
  logic signed [2*CW:0]     e1_hx, e1_hy;
  logic signed [2*CW+1:0]   e1_ox2, e1_oy2;
  logic [2*TW-1:0]          e1_rr;
  ray_t                     e1_ray, e2_ray;
  logic [AW-1:0]            e2_a;
  logic signed [HW-1:0]     e2_h;
  logic signed [CCW-1:0]    e2_c;
  fr_t                      e3_fr, e4_fr, e5_fr;
  logic [HMW-1:0]           e3_hm;
  logic [CMW-1:0]           e3_cm;
  logic                     e3_cneg, e4_cneg, e5_cneg;
  logic [2*SPL-1:0]         e4_hll, e4_all, e4_alh;
  logic [HMW-1:0]           e4_hlh;
  logic [2*(HMW-SPL)-1:0]   e4_hhh;
  logic [AW-1:0]            e4_ahl;
  logic [CMW-1:0]           e4_ahh;
  logic [DW-1:0]            e5_h2, e5_ac;
  logic [DW:0]              e5_dd;

  always_ff @(posedge clk) begin
    e0_ocx <= OCW'(origin_x) - OCW'(center_x);
    e0_ocy <= OCW'(origin_y) - OCW'(center_y);
    e0_ox  <= origin_x;
    e0_oy  <= origin_y;
    e0_dx  <= dir_x;
    e0_dy  <= dir_y;
    e0_md  <= max_dist;
    e0_r   <= circle_radius;

    e1_dxx <= e0_dx * e0_dx;
    e1_dyy <= e0_dy * e0_dy;
    e1_hx  <= e0_ocx * e0_dx;
    e1_hy  <= e0_ocy * e0_dy;
    e1_ox2 <= e0_ocx * e0_ocx;
    e1_oy2 <= e0_ocy * e0_ocy;
    e1_rr  <= e0_r * e0_r;
    e1_ray <= '{ox: e0_ox, oy: e0_oy, dx: e0_dx, dy: e0_dy, md: e0_md, miss: 1'b0};

    e2_a   <= e1_dxx[AW-1:0] + e1_dyy[AW-1:0];
    e2_h   <= HW'(e1_hx) + HW'(e1_hy);
    e2_c   <= CCW'(e1_ox2) + CCW'(e1_oy2) - $signed(CCW'(e1_rr));
    e2_ray <= e1_ray;

    e3_fr   <= '{h: e2_h, a: e2_a, r: with_miss(e2_ray, e2_a == '0)};
    e3_hm   <= e2_h[HW-1] ? HMW'(-e2_h) : HMW'(e2_h);
    e3_cm   <= e2_c[CCW-1] ? CMW'(-e2_c) : CMW'(e2_c);
    e3_cneg <= e2_c[CCW-1];

    // wide products as registered partial products
    e4_hll  <= e3_hm[SPL-1:0] * e3_hm[SPL-1:0];
    e4_hlh  <= e3_hm[SPL-1:0] * e3_hm[HMW-1:SPL];
    e4_hhh  <= e3_hm[HMW-1:SPL] * e3_hm[HMW-1:SPL];
    e4_all  <= e3_fr.a[SPL-1:0] * e3_cm[SPL-1:0];
    e4_alh  <= e3_fr.a[SPL-1:0] * e3_cm[CMW-1:SPL];
    e4_ahl  <= e3_fr.a[AW-1:SPL] * e3_cm[SPL-1:0];
    e4_ahh  <= e3_fr.a[AW-1:SPL] * e3_cm[CMW-1:SPL];
    e4_fr   <= e3_fr;
    e4_cneg <= e3_cneg;

    e5_h2   <= (DW'(e4_hhh) << (2 * SPL)) + (DW'(e4_hlh) << (SPL + 1)) + DW'(e4_hll);
    e5_ac   <= (DW'(e4_ahh) << (2 * SPL)) + (DW'(e4_alh) << SPL) + (DW'(e4_ahl) << SPL)
               + DW'(e4_all);
    e5_fr   <= e4_fr;
    e5_cneg <= e4_cneg;
  end

  assign e5_dd = {1'b0, e5_h2} - {1'b0, e5_ac};

  // discriminant root, one bit per stage
  sq1_t q1 [0:SQW];

  always_ff @(posedge clk) begin
    q1[0].rem  <= '0;
    q1[0].root <= '0;
    q1[0].rad  <= e5_cneg ? (e5_h2 + e5_ac) : e5_dd[DW-1:0];
    q1[0].sb   <= '{h: e5_fr.h, a: e5_fr.a,
                    r: with_miss(e5_fr.r, e5_fr.r.miss || (!e5_cneg && e5_dd[DW]))};
    for (int k = 0; k < SQW; k++) begin
      q1[k+1] <= sq1_step(q1[k]);
    end
  end

  // root selection: the nearer root unless it rounds to zero or lies behind
  logic signed [NSW-1:0] r1_n1, r1_n2;
  fr_t                   r1_fr;
  logic [NMW-1:0]        r2_num;
  logic [AW-1:0]         r2_a;
  ray_t                  r2_ray;
  logic                  r2_use1, r2_n1pos, r2_n2pos;

  always_ff @(posedge clk) begin
    r1_n1 <= -NSW'(q1[SQW].sb.h) - $signed(NSW'(q1[SQW].root));
    r1_n2 <= -NSW'(q1[SQW].sb.h) + $signed(NSW'(q1[SQW].root));
    r1_fr <= q1[SQW].sb;
  end

  always_comb begin
    r2_n1pos = !r1_n1[NSW-1] && (r1_n1 != '0);
    r2_n2pos = !r1_n2[NSW-1] && (r1_n2 != '0);
    r2_use1  = r2_n1pos && ({r1_n1[NMW-1:0], {FW{1'b0}}} >= (NMW + FW)'(r1_fr.a));
  end

  always_ff @(posedge clk) begin
    r2_num <= r2_use1 ? r1_n1[NMW-1:0] : r1_n2[NMW-1:0];
    r2_a   <= r1_fr.a;
    r2_ray <= with_miss(r1_fr.r, r1_fr.r.miss || (!r2_use1 && !r2_n2pos));
  end

  // distance divider, numerator shifted by the fraction bits
  logic [NMW+FW-1:0] r2_nn;
  logic              r2_ovf;
  dv_t               dv [0:TW];

  assign r2_nn  = {r2_num, {FW{1'b0}}};
  assign r2_ovf = r2_num >= {r2_a, {(TW - FW){1'b0}}};

  always_ff @(posedge clk) begin
    dv[0].rem <= AW'(r2_nn[NMW+FW-1:TW]);
    dv[0].q   <= '0;
    dv[0].nlo <= r2_nn[TW-1:0];
    dv[0].a   <= r2_a;
    dv[0].r   <= with_miss(r2_ray, r2_ray.miss || r2_ovf);
    for (int k = 0; k < TW; k++) begin
      dv[k+1] <= dv_step(dv[k]);
    end
  end

  // hit point, offset from the center, squared length
  logic                    h1_hit, h2_hit, h3_hit;
  logic [TW-1:0]           h1_t, h2_t, h3_t;
  logic signed [PW-1:0]    h1_prx, h1_pry;
  logic signed [CW-1:0]    h1_ox, h1_oy, h3_hitx, h3_hity;
  logic signed [PXW-1:0]   h2_px, h2_py;
  logic signed [VW-1:0]    h3_vx, h3_vy;
  hp_t                     h4_sb, h5_sb;
  logic [2*VSP-1:0]        h5_xll, h5_yll;
  logic [VMW-1:0]          h5_xlh, h5_ylh;
  logic [2*(VMW-VSP)-1:0]  h5_xhh, h5_yhh;
  logic [2*VMW-1:0]        h6_sx, h6_sy;
  hp_t                     h6_sb;

  always_ff @(posedge clk) begin
    h1_hit <= !dv[TW].r.miss && (dv[TW].q != '0) && (dv[TW].q <= dv[TW].r.md);
    h1_t   <= dv[TW].q;
    h1_prx <= dv[TW].r.dx * $signed({1'b0, dv[TW].q});
    h1_pry <= dv[TW].r.dy * $signed({1'b0, dv[TW].q});
    h1_ox  <= dv[TW].r.ox;
    h1_oy  <= dv[TW].r.oy;

    // arithmetic shift rounds toward minus infinity
    h2_hit <= h1_hit;
    h2_t   <= h1_t;
    h2_px  <= PXW'(h1_ox) + PXW'(h1_prx >>> FW);
    h2_py  <= PXW'(h1_oy) + PXW'(h1_pry >>> FW);

    h3_hit  <= h2_hit;
    h3_t    <= h2_t;
    h3_hitx <= sat_cw(h2_px);
    h3_hity <= sat_cw(h2_py);
    h3_vx   <= VW'(h2_px) - VW'(center_x);
    h3_vy   <= VW'(h2_py) - VW'(center_y);

    h4_sb.hit  <= h3_hit;
    h4_sb.t    <= h3_t;
    h4_sb.hitx <= h3_hitx;
    h4_sb.hity <= h3_hity;
    h4_sb.vxm  <= h3_vx[VW-1] ? VMW'(-h3_vx) : VMW'(h3_vx);
    h4_sb.vym  <= h3_vy[VW-1] ? VMW'(-h3_vy) : VMW'(h3_vy);
    h4_sb.vxn  <= h3_vx[VW-1];
    h4_sb.vyn  <= h3_vy[VW-1];

    h5_xll <= h4_sb.vxm[VSP-1:0] * h4_sb.vxm[VSP-1:0];
    h5_xlh <= h4_sb.vxm[VSP-1:0] * h4_sb.vxm[VMW-1:VSP];
    h5_xhh <= h4_sb.vxm[VMW-1:VSP] * h4_sb.vxm[VMW-1:VSP];
    h5_yll <= h4_sb.vym[VSP-1:0] * h4_sb.vym[VSP-1:0];
    h5_ylh <= h4_sb.vym[VSP-1:0] * h4_sb.vym[VMW-1:VSP];
    h5_yhh <= h4_sb.vym[VMW-1:VSP] * h4_sb.vym[VMW-1:VSP];
    h5_sb  <= h4_sb;

    h6_sx <= ((2 * VMW)'(h5_xhh) << (2 * VSP)) + ((2 * VMW)'(h5_xlh) << (VSP + 1))
             + (2 * VMW)'(h5_xll);
    h6_sy <= ((2 * VMW)'(h5_yhh) << (2 * VSP)) + ((2 * VMW)'(h5_ylh) << (VSP + 1))
             + (2 * VMW)'(h5_yll);
    h6_sb <= h5_sb;
  end

  // normal length root
  sq2_t q2 [0:LW];

  always_ff @(posedge clk) begin
    q2[0].rem  <= '0;
    q2[0].root <= '0;
    q2[0].rad  <= SS2'(h6_sx) + SS2'(h6_sy);
    q2[0].sb   <= h6_sb;
    for (int k = 0; k < LW; k++) begin
      q2[k+1] <= sq2_step(q2[k]);
    end
  end

  // normal dividers, |v| never exceeds the length so the quotient fits
  logic [VMW+NF-1:0] nnx, nny;
  dn_t               dn [0:NQW];

  assign nnx = {q2[LW].sb.vxm, {NF{1'b0}}};
  assign nny = {q2[LW].sb.vym, {NF{1'b0}}};

  always_ff @(posedge clk) begin
    dn[0].len  <= q2[LW].root;
    dn[0].remx <= LW'(nnx[VMW+NF-1:NQW]);
    dn[0].nlx  <= nnx[NQW-1:0];
    dn[0].qx   <= '0;
    dn[0].remy <= LW'(nny[VMW+NF-1:NQW]);
    dn[0].nly  <= nny[NQW-1:0];
    dn[0].qy   <= '0;
    dn[0].sb   <= q2[LW].sb;
    for (int k = 0; k < NQW; k++) begin
      dn[k+1] <= dn_step(dn[k]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (dn[NQW].sb.hit) begin
      hit   <= 1'b1;
      hit_t <= dn[NQW].sb.t;
      hit_x <= dn[NQW].sb.hitx;
      hit_y <= dn[NQW].sb.hity;
      if (dn[NQW].len == '0) begin
        normal_x <= '0;
        normal_y <= '0;
      end else begin
        normal_x <= dn[NQW].sb.vxn ? -NOW'(dn[NQW].qx) : NOW'(dn[NQW].qx);
        normal_y <= dn[NQW].sb.vyn ? -NOW'(dn[NQW].qy) : NOW'(dn[NQW].qy);
      end
    end else begin
      hit      <= 1'b0;
      hit_t    <= '0;
      hit_x    <= '0;
      hit_y    <= '0;
      normal_x <= '0;
      normal_y <= '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> hit_t == '0 && hit_x == '0 && hit_y == '0 &&
                     normal_x == '0 && normal_y == '0)
    else $error("miss item carries nonzero fields");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> hit_t != '0)
    else $error("hit item with zero distance");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> $signed(normal_x) <= NORM_ONE && $signed(normal_x) >= -NORM_ONE &&
                    $signed(normal_y) <= NORM_ONE && $signed(normal_y) >= -NORM_ONE)
    else $error("normal component out of range");

  a_cfg_cx: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && paddr[PAW-1:2] == REG_CX |=> center_x == $past(pwdata[CW-1:0]))
    else $error("center x write lost");

endmodule

>>> verif/rci_checker.sv
// result checker for the ray / circle intersector: tracks registers, predicts and compares
`timescale 1ns / 100ps
module rci_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [rci_pkg::PAW-1:0]          paddr,
  input  logic [31:0]                      pwdata,
  input  logic signed [rci_pkg::CW-1:0]    origin_x,
  input  logic signed [rci_pkg::CW-1:0]    origin_y,
  input  logic signed [rci_pkg::CW-1:0]    dir_x,
  input  logic signed [rci_pkg::CW-1:0]    dir_y,
  input  logic [rci_pkg::TW-1:0]           max_dist,
  input  logic                             done,
  input  logic                             hit,
  input  logic [rci_pkg::TW-1:0]           hit_t,
  input  logic signed [rci_pkg::CW-1:0]    hit_x,
  input  logic signed [rci_pkg::CW-1:0]    hit_y,
  input  logic signed [rci_pkg::NOW-1:0]   normal_x,
  input  logic signed [rci_pkg::NOW-1:0]   normal_y,
  output int                               fails,
  output int                               pending
);
  import rci_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic                  hit;
    logic [TW-1:0]         t;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [NOW-1:0] nx;
    logic signed [NOW-1:0] ny;
  } hit_rec_t;

  logic signed [CW-1:0] center_x, center_y;
  logic [TW-1:0]        radius;
  hit_rec_t             hits_due[$];

  assign pending = hits_due.size();

  function automatic wide_t int_sqrt(input wide_t n);
    logic [191:0] root, cand;
    root = '0;
    for (int i = 95; i >= 0; i--) begin
      cand = root | (192'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return wide_t'(root);
  endfunction

  function automatic wide_t clamp_coord(input wide_t v);
    wide_t lo, hi;
    lo = -(wide_t'(1) <<< (CW - 1));
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic hit_rec_t predict_hit(input logic signed [CW-1:0] ox_i,
                                           input logic signed [CW-1:0] oy_i,
                                           input logic signed [CW-1:0] dx_i,
                                           input logic signed [CW-1:0] dy_i,
                                           input logic [TW-1:0] md_i);
    wide_t ox, oy, dx, dy, md, cx, cy, rr, ocx, ocy, a, h, c, disc, sq, num, t;
    wide_t px, py, vx, vy, len;
    logic have;
    hit_rec_t res;
    res = '0;
    have = 1'b0;
    ox = wide_t'(ox_i); oy = wide_t'(oy_i); dx = wide_t'(dx_i); dy = wide_t'(dy_i);
    md = wide_t'(md_i);
    cx = wide_t'(center_x); cy = wide_t'(center_y); rr = wide_t'(radius);
    ocx = ox - cx;
    ocy = oy - cy;
    a = dx * dx + dy * dy;
    if (a == 0) return res;
    h = ocx * dx + ocy * dy;
    c = ocx * ocx + ocy * ocy - rr * rr;
    disc = h * h - a * c;
    if (disc < 0) return res;
    sq = int_sqrt(disc);
    t = 0;
    num = -h - sq;
    if (num > 0) begin
      t = (num <<< FW) / a;
      have = (t != 0);
    end
    // near root rounded to zero or behind the origin: fall back to the far one
    if (!have) begin
      num = -h + sq;
      t = (num > 0) ? (num <<< FW) / a : 0;
    end
    if (t == 0 || t > md) return res;
    px = ox + ((dx * t) >>> FW);
    py = oy + ((dy * t) >>> FW);
    vx = px - cx;
    vy = py - cy;
    len = int_sqrt(vx * vx + vy * vy);
    res.hit = 1'b1;
    res.t = t[TW-1:0];
    res.x = CW'(clamp_coord(px));
    res.y = CW'(clamp_coord(py));
    if (len != 0) begin
      res.nx = NOW'((vx <<< NF) / len);
      res.ny = NOW'((vy <<< NF) / len);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hit_rec_t want, got;
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= R_RESET;
      fails    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PAW-1:2])
          REG_CX: center_x <= pwdata;
          REG_CY: center_y <= pwdata;
          REG_R:  radius   <= pwdata[TW-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        hits_due.push_back(predict_hit(origin_x, origin_y, dir_x, dir_y, max_dist));
      if (done) begin
        got = '{hit, hit_t, hit_x, hit_y, normal_x, normal_y};
        if (hits_due.size() == 0) begin
          if (fails < 10) $display("unexpected result: %p", got);
          fails <= fails + 1;
        end else begin
          want = hits_due.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("mismatch: expected %p, got %p", want, got);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_top.sv
// stimulus and verdict for the ray / circle intersector
`timescale 1ns / 100ps
module tb_top;
  import rci_pkg::*;

  localparam int LIMIT = 600000;

  logic clk, rst, start, busy;
  logic psel, penable, pwrite, pready;
  logic [PAW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic signed [CW-1:0] origin_x, origin_y, dir_x, dir_y;
  logic [TW-1:0] max_dist;
  logic done, hit;
  logic [TW-1:0] hit_t;
  logic signed [CW-1:0] hit_x, hit_y;
  logic signed [NOW-1:0] normal_x, normal_y;
  int fails, pending, cycles;
  logic signed [CW-1:0] aim_x, aim_y;

  ray_circle_intersect dut (.*);

  rci_checker chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [RIW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] r);
    aim_x = cx; aim_y = cy;
    reg_write(REG_CX, cx);
    reg_write(REG_CY, cy);
    reg_write(REG_R, r);
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [31:0] dx, input logic [31:0] dy,
                          input logic [31:0] md);
    origin_x = ox; origin_y = oy; dir_x = dx; dir_y = dy;
    max_dist = md[TW-1:0];
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n, roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) n = 0;
    else if (roll < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_rays(input int count);
    logic [31:0] ox, oy, dx, dy, md;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 65) begin
        // aimed near the circle with moderate direction so most rays resolve
        ox = aim_x + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        oy = aim_y + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        dx = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        dy = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        md = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h0040_0000)
                                         : 32'h7fff_ffff;
      end else begin
        ox = $urandom; oy = $urandom; dx = $urandom; dy = $urandom; md = $urandom;
      end
      send_ray(ox, oy, dx, dy, md);
      sender_gap();
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    origin_x = '0; origin_y = '0; dir_x = '0; dir_y = '0; max_dist = '0;
    aim_x = '0; aim_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed rays on the reset circle (unit radius at origin)
    send_ray(32'hfffd_0000, 0, 0, 0, 32'h7fff_ffff);               // zero direction
    send_ray(32'hfffd_0000, 0, 32'h0001_0000, 0, 32'h7fff_ffff);   // clean hit at t=2
    send_ray(32'hfffd_0000, 0, 32'h0001_0000, 0, 32'h0001_0000);   // beyond max distance
    send_ray(32'hfffd_0000, 0, 32'hffff_0000, 0, 32'h7fff_ffff);   // pointing away
    send_ray(32'hfffd_0000, 32'h0001_0000, 32'h0001_0000, 0, 32'h7fff_ffff); // tangent
    send_ray(32'hfffd_0000, 32'h0002_0000, 32'h0001_0000, 0, 32'h7fff_ffff); // clear miss
    send_ray(0, 0, 32'h0000_8000, 32'h0000_8000, 32'h7fff_ffff);   // from center
    send_ray(32'h0000_4000, 0, 0, 32'h0001_0000, 32'h7fff_ffff);   // from inside
    send_ray(32'h0001_0000, 0, 32'hffff_0000, 0, 32'h7fff_ffff);   // on surface, inward
    send_ray(32'h0001_0000, 0, 32'h0001_0000, 0, 32'h7fff_ffff);   // on surface, outward
    send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'hffff_0000, 0, 32'h0000_0001, 0, 32'h7fff_ffff);   // tiny direction
    send_ray(32'hfffd_0000, 0, 32'h0001_0000, 0, 32'hffff_ffff);   // extra max_dist bit
    drain();
    random_rays(160);
    drain();

    // zero radius: only a ray through the center point can hit
    set_circle(32'h0003_0000, 32'hfffe_0000, 0);
    send_ray(0, 32'hfffe_0000, 32'h0001_0000, 0, 32'h7fff_ffff);
    random_rays(120);
    drain();

    // extremes of the registers, with a hit point that saturates
    set_circle(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_ray(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    random_rays(150);
    drain();
    set_circle(32'h8000_0000, 32'h7fff_ffff, 32'h0004_0000);
    random_rays(150);
    drain();
    for (int k = 0; k < 3; k++) begin
      set_circle($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                 $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                 $urandom_range(1, 32'h0010_0000));
      random_rays(120);
      drain();
    end

    repeat (LAT + 20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> ray_circle_intersect.f
hw/rtl/rci_pkg.sv
hw/rtl/ray_circle_intersect.sv
verif/rci_checker.sv
verif/tb_top.sv
